// ----- design/vertex_transform_perspective_divide_macros.svh -----
// Assertion macros used by the checker file of the vertex transform block.
// No dependencies.
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_MACROS_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define VTPD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define VTPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- design/vtpd_pkg.sv -----
// Package of the vertex transform block: payload types, float constants and the
// float32 multiply and add functions. No dependencies.
`default_nettype none
package vtpd_pkg;
   localparam int unsigned CfgCount = 8;
   localparam int unsigned CfgIndexWidth = 4;
   localparam int unsigned DivBitsPerStage = 2;
   localparam logic [31:0] FloatOne = 32'h3F800000;
   localparam logic [31:0] CanonNan = 32'h7FC00000;
   localparam logic [63:0] CfgReset [CfgCount] = '{
      64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000, 64'h0,
      64'h0, 64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000};

   typedef struct packed {
      logic [31:0] point_x;
      logic [31:0] point_y;
      logic [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic [31:0] ndc_x;
      logic [31:0] ndc_y;
      logic [31:0] ndc_z;
      logic        rejected;
   } rsp_type;

   // Unpacked float: special flags, sign, unbiased exponent, significand.
   typedef struct packed {
      logic        nan;
      logic        inf;
      logic        zero;
      logic        sign;
      logic signed [9:0] expo;
      logic [23:0] man;
   } unp_type;

   function automatic unp_type fp_unpack(input logic [31:0] a);
      unp_type u;
      u.sign = a[31];
      u.nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      u.inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      u.zero = (a[30:0] == 31'd0);
      if (a[30:23] == 8'd0) begin
         u.expo = -10'sd126;
         u.man  = {1'b0, a[22:0]};
      end else begin
         u.expo = $signed({2'b00, a[30:23]}) - 10'sd127;
         u.man  = {1'b1, a[22:0]};
      end
      return u;
   endfunction

   // Rounds sign * sig * 2^(e - 50) where sig is 52 bits and stk is a sticky bit
   // beyond bit 0; sig must be nonzero. Handles normalization, subnormals, overflow.
   function automatic logic [31:0] fp_round(input logic s, input logic signed [11:0] e,
                                            input logic [51:0] sig, input logic stk);
      logic [5:0]  lz;
      logic [51:0] n;
      logic signed [11:0] be;
      logic [51:0] sh;
      logic [5:0]  rs;
      logic        st;
      logic [24:0] m;
      logic        g;
      logic        r;
      logic [31:0] res;
      lz = 6'd0;
      for (int i = 0; i < 52; i++) begin
         if (sig[i]) lz = 6'(51 - i);
      end
      n  = sig << lz;
      // value = n * 2^(e - 50 - lz), leading bit at 51 -> exponent e + 1 - lz
      be = e + 12'sd1 - 12'(lz) + 12'sd127;
      st = stk;
      if (be <= 12'sd0) begin
         rs = (be < -12'sd40) ? 6'd42 : 6'(12'sd1 - be);
         sh = n >> rs;
         for (int i = 0; i < 52; i++) begin
            if (i < rs && n[i]) st = 1'b1;
         end
         be = 12'sd0;
      end else begin
         sh = n;
      end
      m = {1'b0, sh[51:28]};
      g = sh[27];
      r = (|sh[26:0]) | st;
      if (g && (r || m[0])) m = m + 25'd1;
      if (m[24]) begin
         m  = m >> 1;
         be = be + 12'sd1;
      end else if (be == 12'sd0 && m[23]) begin
         be = 12'sd1;
      end
      if (be >= 12'sd255) res = {s, 8'hFF, 23'd0};
      else res = {s, be[7:0], m[22:0]};
      return res;
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      unp_type ua;
      unp_type ub;
      logic    s;
      logic [47:0] p;
      ua = fp_unpack(a);
      ub = fp_unpack(b);
      s  = ua.sign ^ ub.sign;
      p  = ua.man * ub.man;
      if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ub.inf && ua.zero))
         return CanonNan;
      if (ua.inf || ub.inf) return {s, 8'hFF, 23'd0};
      if (p == 48'd0) return {s, 31'd0};
      // value = p * 2^(ea+eb-46) = {p,4'b0} * 2^(ea+eb-50)
      return fp_round(s, 12'(ua.expo) + 12'(ub.expo), {p, 4'd0}, 1'b0);
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      unp_type ua;
      unp_type ub;
      unp_type t;
      logic [11:0] d;
      logic [51:0] ma;
      logic [51:0] mb;
      logic [51:0] sum;
      logic        stk;
      ua = fp_unpack(a);
      ub = fp_unpack(b);
      if (ua.nan || ub.nan || (ua.inf && ub.inf && ua.sign != ub.sign)) return CanonNan;
      if (ua.inf) return a;
      if (ub.inf) return b;
      if (ub.expo > ua.expo || (ub.expo == ua.expo && ub.man > ua.man)) begin
         t = ua; ua = ub; ub = t;
      end
      d   = 12'(ua.expo - ub.expo);
      ma  = {2'b00, ua.man, 26'd0};
      mb  = {2'b00, ub.man, 26'd0};
      stk = 1'b0;
      if (d > 12'd50) begin
         stk = |mb;
         mb  = 52'd0;
      end else begin
         for (int i = 0; i < 52; i++) begin
            if (i < d && mb[i]) stk = 1'b1;
         end
         mb = mb >> d;
      end
      if (ua.sign == ub.sign) sum = ma + mb;
      else sum = ma - mb - 52'(stk);
      if (sum == 52'd0 && !stk) begin
         if (ua.zero && ub.zero) return {ua.sign & ub.sign, 31'd0};
         return 32'd0;
      end
      // ma holds man * 2^26, leading at bit 49: value = sum * 2^(ea - 23 - 26)
      return fp_round(ua.sign, 12'(ua.expo) + 12'sd1, sum, stk);
   endfunction

   // a < 1.0 as an IEEE ordered compare; NaN gives false.
   function automatic logic fp_below_one(input logic [31:0] a);
      if ((a[30:23] == 8'hFF) && (a[22:0] != 23'd0)) return 1'b0;
      if (a[31]) return 1'b1;
      return a[30:0] < FloatOne[30:0];
   endfunction
endpackage
`default_nettype wire

// ----- design/vertex_transform_perspective_divide.sv -----
// Top level of the vertex transform with perspective divide: matrix registers,
// transform pipeline and output skid. Depends on vtpd_pkg and vtpd_divider.
//
//   channel | direction | beat contents
//   req     | in        | point_x, point_y, point_z (float32)
//   rsp     | out       | ndc_x, ndc_y, ndc_z (float32), rejected
//   csr     | in        | write of one 64-bit matrix register
//
// One beat is accepted per cycle while req_stall is low. It passes four transform
// stages (multiply, two accumulate adds, translation add), fifteen divider stages
// (operand normalization and fourteen two-bit quotient stages) and the output queue.
// Reset is synchronous and loads the identity matrix and clears every valid bit.
// A stall on rsp first fills the two-entry output queue; once it is full the whole
// pipeline freezes and req_stall stays high until a queued beat has left.
`default_nettype none
module vertex_transform_perspective_divide
   import vtpd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire req_type                  req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_type                       rsp_data,
   input  wire logic                     csr_write,
   input  wire logic [CfgIndexWidth-1:0] csr_index,
   input  wire logic [63:0]              csr_data
);
   logic [63:0] cfg_ff [CfgCount];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CfgCount; i++) cfg_ff[i] <= CfgReset[i];
      end else if (csr_write && (32'(csr_index) < CfgCount)) begin
         cfg_ff[csr_index[$clog2(CfgCount)-1:0]] <= csr_data;
      end
   end

   function automatic logic [31:0] elem(input logic [1:0] c, input logic [1:0] r);
      logic [63:0] w;
      w = cfg_ff[{c, r[1]}];
      return r[0] ? w[63:32] : w[31:0];
   endfunction

   // The pipeline advances unless the skid buffer is full.
   logic [1:0] cnt_ff;
   logic       advance;
   assign advance = (cnt_ff != 2'd2);
   assign req_stall = !advance;

   // Stage 1: twelve products.
   logic [31:0] px_ff [4];
   logic [31:0] py_ff [4];
   logic [31:0] pz_ff [4];
   logic [31:0] a1_ff [4];
   logic [31:0] pz2_ff [4];
   logic [31:0] a2_ff [4];
   logic [31:0] c_ff [4];
   logic [3:0]  v_ff;
   logic [3:0]  v_in;
   assign v_in = {v_ff[2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (advance) v_ff <= v_in;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 4; r++) begin
            px_ff[r]  <= fp_mul(req_data.point_x, elem(2'd0, 2'(r)));
            py_ff[r]  <= fp_mul(req_data.point_y, elem(2'd1, 2'(r)));
            pz_ff[r]  <= fp_mul(req_data.point_z, elem(2'd2, 2'(r)));
            a1_ff[r]  <= fp_add(px_ff[r], py_ff[r]);
            pz2_ff[r] <= pz_ff[r];
            a2_ff[r]  <= fp_add(a1_ff[r], pz2_ff[r]);
            c_ff[r]   <= fp_add(a2_ff[r], elem(2'd3, 2'(r)));
         end
      end
   end

   // Rejection travels beside the divider in a matching delay line.
   localparam int unsigned DivLat = 28 / DivBitsPerStage + 1;
   logic [DivLat-1:0] rej_ff;
   always_ff @(posedge clock) begin
      if (advance) rej_ff <= {rej_ff[DivLat-2:0], fp_below_one(c_ff[3])};
   end

   logic        dv [3];
   logic [31:0] dq [3];
   for (genvar g = 0; g < 3; g++) begin : g_div
      vtpd_divider u_div (
         .clock(clock), .reset(reset), .advance(advance), .in_valid(v_ff[3]),
         .num(c_ff[g]), .den(c_ff[3]), .out_valid(dv[g]), .quo(dq[g]));
   end

   rsp_type res;
   always_comb begin
      res.rejected = rej_ff[DivLat-1];
      res.ndc_x = res.rejected ? 32'd0 : dq[0];
      res.ndc_y = res.rejected ? 32'd0 : dq[1];
      res.ndc_z = res.rejected ? 32'd0 : dq[2];
   end

   // Two-entry output queue; the pipeline stops while it is full.
   rsp_type q_ff [2];
   logic    push;
   logic    pop;
   assign push = advance && dv[0];
   assign pop  = (cnt_ff != 2'd0) && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= 2'd0;
      else cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
   end

   // A push together with a pop only happens with one beat queued, so the new
   // beat goes straight to the head.
   always_ff @(posedge clock) begin
      if (push && (pop || (cnt_ff == 2'd0))) q_ff[0] <= res;
      else if (pop) q_ff[0] <= q_ff[1];
      if (push && !pop && (cnt_ff == 2'd1)) q_ff[1] <= res;
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = q_ff[0];
endmodule
`default_nettype wire

// ----- design/vtpd_divider.sv -----
// Pipelined float32 divider, two quotient bits per stage, with valid and stall.
// Depends on vtpd_pkg.
`default_nettype none
module vtpd_divider
   import vtpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic        in_valid,
   input  wire logic [31:0] num,
   input  wire logic [31:0] den,
   output logic             out_valid,
   output logic [31:0]      quo
);
   localparam int unsigned QBits = 28;
   localparam int unsigned Stages = QBits / DivBitsPerStage;

   typedef struct packed {
      logic        special;
      logic [31:0] special_val;
      logic        sign;
      logic signed [11:0] expo;
      logic [25:0] rem;
      logic [23:0] dv;
      logic [QBits-1:0] q;
   } div_type;

   div_type st_ff [Stages+1];
   div_type st_in [Stages+1];
   logic [Stages:0] v_ff;
   logic [Stages:0] v_in;

   always_comb begin
      unp_type ua;
      unp_type ub;
      logic [5:0] la;
      logic [5:0] lb;
      logic [23:0] na;
      logic [23:0] nb;
      ua = fp_unpack(num);
      ub = fp_unpack(den);
      la = 6'd0;
      lb = 6'd0;
      for (int i = 0; i < 24; i++) begin
         if (ua.man[i]) la = 6'(23 - i);
         if (ub.man[i]) lb = 6'(23 - i);
      end
      na = ua.man << la;
      nb = ub.man << lb;
      st_in[0] = '0;
      st_in[0].sign = ua.sign ^ ub.sign;
      if (ua.nan || ub.nan || (ua.inf && ub.inf) || (ua.zero && ub.zero)) begin
         st_in[0].special = 1'b1;
         st_in[0].special_val = CanonNan;
      end else if (ua.inf || ub.zero) begin
         st_in[0].special = 1'b1;
         st_in[0].special_val = {ua.sign ^ ub.sign, 8'hFF, 23'd0};
      end else if (ua.zero || ub.inf) begin
         st_in[0].special = 1'b1;
         st_in[0].special_val = {ua.sign ^ ub.sign, 31'd0};
      end
      st_in[0].expo = 12'(ua.expo) - 12'(la) - 12'(ub.expo) + 12'(lb);
      st_in[0].rem = {2'b00, na};
      st_in[0].dv = nb;
      for (int s = 1; s <= Stages; s++) begin
         st_in[s] = st_ff[s-1];
         for (int k = 0; k < DivBitsPerStage; k++) begin
            if (st_in[s].rem >= {2'b00, st_in[s].dv}) begin
               st_in[s].rem = st_in[s].rem - {2'b00, st_in[s].dv};
               st_in[s].q = {st_in[s].q[QBits-2:0], 1'b1};
            end else begin
               st_in[s].q = {st_in[s].q[QBits-2:0], 1'b0};
            end
            st_in[s].rem = {st_in[s].rem[24:0], 1'b0};
         end
      end
   end

   always_comb begin
      v_in = {v_ff[Stages-1:0], in_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s <= Stages; s++) st_ff[s] <= st_in[s];
      end
   end

   // Quotient q has its first bit at weight 2^0 (q in [0.5,2) scaled by 2^27).
   always_comb begin
      div_type f;
      f = st_ff[Stages];
      out_valid = v_ff[Stages];
      if (f.special) quo = f.special_val;
      else quo = fp_round(f.sign, f.expo - 12'sd27 + 12'sd50 - 12'sd20,
                          {f.q, 24'd0} >> 4, f.rem != 26'd0);
   end
endmodule
`default_nettype wire

// ----- design/vtpd_checker.sv -----
// Port-level checker of the vertex transform block and its bind.
// Depends on vtpd_pkg and the assertion macro header.
`default_nettype none
`include "vertex_transform_perspective_divide_macros.svh"
module vtpd_checker
   import vtpd_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);
   `VTPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled beat changed")
   `VTPD_ASSERT_IMPL(a_rej_zero, clock, reset, rsp_valid && rsp_data.rejected, rsp_data.ndc_x == 32'd0 && rsp_data.ndc_y == 32'd0 && rsp_data.ndc_z == 32'd0, "rejected beat not zero")
   `VTPD_ASSERT_IMPL(a_stall_full, clock, reset, req_stall, rsp_valid, "input stalled with no pending result")
endmodule
bind vertex_transform_perspective_divide vtpd_checker u_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_data(rsp_data));
`default_nettype wire
